[sv/dcf_pkg.sv]
// shared constants, control word layout and microcode rom for the divisor counter
// no dependencies; used by dcf_div and the top level by scoped names

package dcf_pkg;

	localparam int VALUE_BITS   = 31;
	localparam int IN_TDATA_W   = ((VALUE_BITS + 7) / 8) * 8;
	localparam int COUNT_BITS   = 11;
	localparam int OUT_TDATA_W  = ((COUNT_BITS + 7) / 8) * 8;
	localparam int PROD_BITS    = COUNT_BITS + 1;
	localparam int E_BITS       = $clog2(VALUE_BITS + 1);
	localparam int D_BITS       = VALUE_BITS / 2 + 2;
	localparam int DIV_PAD_BITS = 2 * ((VALUE_BITS + 1) / 2);
	localparam int DIV_STEPS    = DIV_PAD_BITS / 2;
	localparam int DIV_CNT_BITS = $clog2(DIV_STEPS + 1);
	localparam int PC_BITS      = 5;
	localparam int OP_BITS      = 4;
	localparam int COND_BITS    = 4;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// datapath operations
	localparam logic [OP_BITS-1:0] OP_NONE     = 4'd0;
	localparam logic [OP_BITS-1:0] OP_LOAD     = 4'd1;
	localparam logic [OP_BITS-1:0] OP_HALVE    = 4'd2;
	localparam logic [OP_BITS-1:0] OP_MUL_E    = 4'd3;
	localparam logic [OP_BITS-1:0] OP_DIV      = 4'd4;
	localparam logic [OP_BITS-1:0] OP_D_STEP   = 4'd5;
	localparam logic [OP_BITS-1:0] OP_TAKE_Q   = 4'd6;
	localparam logic [OP_BITS-1:0] OP_MUL_STEP = 4'd7;
	localparam logic [OP_BITS-1:0] OP_EMIT     = 4'd8;

	// jump conditions
	localparam logic [COND_BITS-1:0] C_NEVER     = 4'd0;
	localparam logic [COND_BITS-1:0] C_ALWAYS    = 4'd1;
	localparam logic [COND_BITS-1:0] C_NO_IN     = 4'd2;
	localparam logic [COND_BITS-1:0] C_REST_ZERO = 4'd3;
	localparam logic [COND_BITS-1:0] C_REST_ODD  = 4'd4;
	localparam logic [COND_BITS-1:0] C_DIV_BUSY  = 4'd5;
	localparam logic [COND_BITS-1:0] C_D_GT_Q    = 4'd6;
	localparam logic [COND_BITS-1:0] C_REM_ZERO  = 4'd7;
	localparam logic [COND_BITS-1:0] C_OUT_FULL  = 4'd8;

	// program labels
	localparam logic [PC_BITS-1:0] S_ACCEPT   = 5'd0;
	localparam logic [PC_BITS-1:0] S_ZERO     = 5'd1;
	localparam logic [PC_BITS-1:0] S_ODD_TEST = 5'd2;
	localparam logic [PC_BITS-1:0] S_HALVE    = 5'd3;
	localparam logic [PC_BITS-1:0] S_MUL_TWO  = 5'd4;
	localparam logic [PC_BITS-1:0] S_TRIAL    = 5'd5;
	localparam logic [PC_BITS-1:0] S_WAIT_T   = 5'd6;
	localparam logic [PC_BITS-1:0] S_BOUND    = 5'd7;
	localparam logic [PC_BITS-1:0] S_HIT      = 5'd8;
	localparam logic [PC_BITS-1:0] S_NEXT_D   = 5'd9;
	localparam logic [PC_BITS-1:0] S_STRIP    = 5'd10;
	localparam logic [PC_BITS-1:0] S_REDIV    = 5'd11;
	localparam logic [PC_BITS-1:0] S_WAIT_R   = 5'd12;
	localparam logic [PC_BITS-1:0] S_AGAIN    = 5'd13;
	localparam logic [PC_BITS-1:0] S_MUL_D    = 5'd14;
	localparam logic [PC_BITS-1:0] S_OUT_WAIT = 5'd15;
	localparam logic [PC_BITS-1:0] S_EMIT     = 5'd16;

	typedef struct packed {
		logic [OP_BITS-1:0]   op;
		logic [COND_BITS-1:0] cond;
		logic [PC_BITS-1:0]   target;
	} ucode_t;

	// one control word per step: jump to target when cond holds, else fall through
	function automatic ucode_t ucode_rom(input logic [PC_BITS-1:0] pc);
		ucode_t w;
		begin
			unique case (pc)
				S_ACCEPT:   w = '{op: OP_LOAD,     cond: C_NO_IN,     target: S_ACCEPT};
				S_ZERO:     w = '{op: OP_NONE,     cond: C_REST_ZERO, target: S_OUT_WAIT};
				S_ODD_TEST: w = '{op: OP_NONE,     cond: C_REST_ODD,  target: S_MUL_TWO};
				S_HALVE:    w = '{op: OP_HALVE,    cond: C_ALWAYS,    target: S_ODD_TEST};
				S_MUL_TWO:  w = '{op: OP_MUL_E,    cond: C_NEVER,     target: S_ACCEPT};
				S_TRIAL:    w = '{op: OP_DIV,      cond: C_NEVER,     target: S_ACCEPT};
				S_WAIT_T:   w = '{op: OP_NONE,     cond: C_DIV_BUSY,  target: S_WAIT_T};
				S_BOUND:    w = '{op: OP_NONE,     cond: C_D_GT_Q,    target: S_OUT_WAIT};
				S_HIT:      w = '{op: OP_NONE,     cond: C_REM_ZERO,  target: S_STRIP};
				S_NEXT_D:   w = '{op: OP_D_STEP,   cond: C_ALWAYS,    target: S_TRIAL};
				S_STRIP:    w = '{op: OP_TAKE_Q,   cond: C_NEVER,     target: S_ACCEPT};
				S_REDIV:    w = '{op: OP_DIV,      cond: C_NEVER,     target: S_ACCEPT};
				S_WAIT_R:   w = '{op: OP_NONE,     cond: C_DIV_BUSY,  target: S_WAIT_R};
				S_AGAIN:    w = '{op: OP_NONE,     cond: C_REM_ZERO,  target: S_STRIP};
				S_MUL_D:    w = '{op: OP_MUL_STEP, cond: C_ALWAYS,    target: S_TRIAL};
				S_OUT_WAIT: w = '{op: OP_NONE,     cond: C_OUT_FULL,  target: S_OUT_WAIT};
				S_EMIT:     w = '{op: OP_EMIT,     cond: C_ALWAYS,    target: S_ACCEPT};
				default:    w = '{op: OP_NONE,     cond: C_ALWAYS,    target: S_ACCEPT};
			endcase
			return w;
		end
	endfunction

endpackage

[sv/dcf_div.sv]
// shared radix-4 restoring divider, two quotient bits per cycle
// depends on dcf_pkg for the operand widths

module dcf_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [dcf_pkg::VALUE_BITS-1:0]   num,
	input  logic [dcf_pkg::D_BITS-1:0]       den,
	output logic                             busy,
	output logic [dcf_pkg::VALUE_BITS-1:0]   quot,
	output logic [dcf_pkg::D_BITS-1:0]       rem
);

	logic                                busy_q;
	logic [dcf_pkg::DIV_CNT_BITS-1:0]    cnt_q;
	logic [dcf_pkg::DIV_PAD_BITS-1:0]    quo_q;
	logic [dcf_pkg::D_BITS-1:0]          rem_q;
	logic [dcf_pkg::DIV_PAD_BITS-1:0]    quo_nx;
	logic [dcf_pkg::D_BITS-1:0]          rem_nx;

	// two dependent shift-subtract steps, msb first
	always_comb begin
		logic [dcf_pkg::D_BITS:0]   rem_sh;
		logic [dcf_pkg::D_BITS+1:0] diff;
		quo_nx = quo_q;
		rem_nx = rem_q;
		for (int i = 0; i < 2; i++) begin
			rem_sh = {rem_nx, quo_nx[dcf_pkg::DIV_PAD_BITS-1]};
			quo_nx = {quo_nx[dcf_pkg::DIV_PAD_BITS-2:0], 1'b0};
			diff = {1'b0, rem_sh} - {2'b00, den};
			if (!diff[dcf_pkg::D_BITS+1]) begin
				rem_nx = diff[dcf_pkg::D_BITS-1:0];
				quo_nx[0] = 1'b1;
			end else begin
				rem_nx = rem_sh[dcf_pkg::D_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= dcf_pkg::DIV_CNT_BITS'(dcf_pkg::DIV_STEPS - 1);
		end else if (busy_q) begin
			if (cnt_q == '0) begin
				busy_q <= 1'b0;
			end
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dcf_pkg::DIV_PAD_BITS'(num);
			rem_q <= '0;
		end else if (busy_q) begin
			quo_q <= quo_nx;
			rem_q <= rem_nx;
		end
	end

	assign busy = busy_q;
	assign quot = quo_q[dcf_pkg::VALUE_BITS-1:0];
	assign rem  = rem_q;

endmodule

[sv/divisor_count_by_factorization.sv]
// channel  dir  tdata bits (low to high)        notes
// s_axis   in   [30:0] value, [31] zero        one word per count request
// m_axis   out  [10:0] divisor_count, [15:11] 0 one word per request, 0 for value 0
//
// a request runs through a microcoded sequencer over one shared radix-4 divider
// each trial divisor runs one pass of the divider plus sequencing steps
// worst case is a prime near 2^31, about 23170 trials
// a power of two or a small number stops early, once the divisor passes the quotient
// the next word is taken once the result sits in the output register
// reset clears the step counter and the output valid; no clearing pass
// depends on dcf_pkg and dcf_div

module divisor_count_by_factorization (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	input  logic [dcf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,  // value
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	output logic [dcf_pkg::OUT_TDATA_W-1:0] m_axis_tdata   // divisor_count
);

	dcf_pkg::ucode_t                        cw;
	logic [dcf_pkg::PC_BITS-1:0]            pc_q;
	logic                                   jump;
	logic                                   in_fire;
	logic                                   out_fire;

	logic [dcf_pkg::VALUE_BITS-1:0]         rest_q;
	logic [dcf_pkg::D_BITS-1:0]             d_q;
	logic [dcf_pkg::E_BITS-1:0]             e_q;
	logic [dcf_pkg::PROD_BITS-1:0]          prod_q;
	logic                                   out_valid_q;
	logic [dcf_pkg::COUNT_BITS-1:0]         out_count_q;

	logic                                   div_start;
	logic                                   div_busy;
	logic [dcf_pkg::VALUE_BITS-1:0]         div_quot;
	logic [dcf_pkg::D_BITS-1:0]             div_rem;

	logic [dcf_pkg::PROD_BITS+dcf_pkg::E_BITS-1:0] prod_full;
	logic [dcf_pkg::PROD_BITS-1:0]          prod_sat;
	logic [dcf_pkg::PROD_BITS:0]            prod_dbl;
	logic [dcf_pkg::COUNT_BITS-1:0]         count_fin;
	logic [dcf_pkg::VALUE_BITS-1:0]         in_value;

	assign cw            = dcf_pkg::ucode_rom(pc_q);
	assign s_axis_tready = (cw.op == dcf_pkg::OP_LOAD);
	assign in_fire       = s_axis_tvalid && s_axis_tready;
	assign out_fire      = out_valid_q && m_axis_tready;
	assign in_value      = s_axis_tdata[dcf_pkg::VALUE_BITS-1:0];
	assign div_start     = (cw.op == dcf_pkg::OP_DIV);

	always_comb begin
		unique case (cw.cond)
			dcf_pkg::C_NEVER:     jump = 1'b0;
			dcf_pkg::C_ALWAYS:    jump = 1'b1;
			dcf_pkg::C_NO_IN:     jump = !in_fire;
			dcf_pkg::C_REST_ZERO: jump = (rest_q == '0);
			dcf_pkg::C_REST_ODD:  jump = rest_q[0];
			dcf_pkg::C_DIV_BUSY:  jump = div_busy;
			dcf_pkg::C_D_GT_Q:    jump = (dcf_pkg::VALUE_BITS'(d_q) > div_quot);
			dcf_pkg::C_REM_ZERO:  jump = (div_rem == '0);
			dcf_pkg::C_OUT_FULL:  jump = out_valid_q;
			default:              jump = 1'b1;
		endcase
	end

	// running product times (exponent + 1), pinned just above the count range
	assign prod_full = prod_q * dcf_pkg::E_BITS'(e_q + 1'b1);
	assign prod_sat  = (prod_full > (dcf_pkg::PROD_BITS + dcf_pkg::E_BITS)'(dcf_pkg::COUNT_MAX))
	                 ? dcf_pkg::PROD_BITS'({1'b0, dcf_pkg::COUNT_MAX} + 1'b1)
	                 : prod_full[dcf_pkg::PROD_BITS-1:0];

	// a leftover cofactor above one is one more prime
	assign prod_dbl  = (rest_q > dcf_pkg::VALUE_BITS'(1)) ? {prod_q, 1'b0} : {1'b0, prod_q};
	assign count_fin = (prod_dbl > (dcf_pkg::PROD_BITS + 1)'(dcf_pkg::COUNT_MAX))
	                 ? dcf_pkg::COUNT_MAX : prod_dbl[dcf_pkg::COUNT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q        <= dcf_pkg::S_ACCEPT;
			out_valid_q <= 1'b0;
		end else begin
			pc_q <= jump ? cw.target : pc_q + 1'b1;
			if (cw.op == dcf_pkg::OP_EMIT) begin
				out_valid_q <= 1'b1;
			end else if (out_fire) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (cw.op)
			dcf_pkg::OP_LOAD: begin
				if (in_fire) begin
					rest_q <= in_value;
					prod_q <= dcf_pkg::PROD_BITS'(in_value != '0);
					e_q    <= '0;
					d_q    <= dcf_pkg::D_BITS'(3);
				end
			end
			dcf_pkg::OP_HALVE: begin
				rest_q <= rest_q >> 1;
				e_q    <= e_q + 1'b1;
			end
			dcf_pkg::OP_MUL_E: begin
				prod_q <= prod_sat;
				e_q    <= '0;
			end
			dcf_pkg::OP_D_STEP: begin
				d_q <= d_q + dcf_pkg::D_BITS'(2);
			end
			dcf_pkg::OP_TAKE_Q: begin
				rest_q <= div_quot;
				e_q    <= e_q + 1'b1;
			end
			dcf_pkg::OP_MUL_STEP: begin
				prod_q <= prod_sat;
				e_q    <= '0;
				d_q    <= d_q + dcf_pkg::D_BITS'(2);
			end
			dcf_pkg::OP_EMIT: begin
				out_count_q <= count_fin;
			end
			default: begin
			end
		endcase
	end

	dcf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (rest_q),
		.den    (d_q),
		.busy   (div_busy),
		.quot   (div_quot),
		.rem    (div_rem)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = dcf_pkg::OUT_TDATA_W'(out_count_q);

endmodule

[sv/dcf_checker.sv]
// port-level checks for the divisor counter, bound to the top level
// depends on dcf_pkg for the port widths

module dcf_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            s_axis_tvalid,
	input logic                            s_axis_tready,
	input logic                            m_axis_tvalid,
	input logic                            m_axis_tready,
	input logic [dcf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

	// a stalled result word stays up
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
		else $error("result word dropped while stalled");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("result word changed while stalled");

	// one request at a time: the input closes right after a word is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("input still open after taking a word");

	// count never beyond its field, padding bits stay zero
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata[dcf_pkg::OUT_TDATA_W-1:dcf_pkg::COUNT_BITS] == '0))
		else $error("result padding bits set");

endmodule

bind divisor_count_by_factorization dcf_checker u_dcf_checker (.*);
